// ===== hw/rtl/dwem_pkg.sv =====
// Shared types and constants for the DEM window extrema marker.
// Mark codes held in the mark line, per-item control word, config indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dwem_pkg;

  // Config register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA  = 2'd2;

  // Mark line codes
  typedef enum logic [1:0] {
    CODE_NEUTRAL = 2'd0,
    CODE_HIGH    = 2'd1,
    CODE_LOW     = 2'd2
  } dwem_code_t;

  // Control word travelling with an item from issue to the window stage
  typedef struct packed {
    logic sample;   // elevation sample (else flush)
    logic win_en;   // a 2x2 window closes on this sample
    logic emit;     // item gives a result
    logic fl_top;   // flush: cell held in the top carry register
    logic fl_mem;   // flush: cell read from the mark line
    logic fl_bot;   // flush: cell held in the bottom carry register
    logic last;     // final cell of the frame
  } dwem_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dwem_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first when both ports hit the same address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dwem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dwem_seq.sv =====
// Issue sequencer: config registers, raster position and flush counters.
// Classifies each transfer and forms the line memory addresses.
// Depends on dwem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dwem_seq #(
  parameter int MAX_COLUMNS = 2048,
  localparam int IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int CntW = $clog2(MAX_COLUMNS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [dwem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          accept,
  input  wire logic                          cmd,
  output logic                               iss_valid,
  output dwem_pkg::dwem_op_t                 iss_op,
  output logic [IdxW-1:0]                    iss_col,
  output logic [IdxW-1:0]                    iss_waddr,
  output logic [IdxW-1:0]                    iss_raddr,
  output logic signed [31:0]                 nodata
);

  import dwem_pkg::*;

  localparam int ColsRst = (MAX_COLUMNS < 2048) ? MAX_COLUMNS : 2048;

  logic [CntW-1:0] cols_eff;
  logic [15:0]     rows_eff;
  logic [IdxW-1:0] col_pos;
  logic [15:0]     row_pos;
  logic [CntW-1:0] flush_cnt;

  logic            sample_ok;
  logic            flush_ok;
  logic            col_last;
  logic            f_last;
  logic [IdxW-1:0] cm1;
  logic            restart;
  logic [11:0]     cols_wr;

  assign cm1     = IdxW'(cols_eff - CntW'(1));
  assign cols_wr = cfg_data[11:0];
  assign restart = cfg_valid && (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS);

  always_comb begin
    sample_ok = !cmd && (row_pos < rows_eff);
    flush_ok  = cmd && !(row_pos < rows_eff);
    col_last  = (col_pos == cm1);
    f_last    = (flush_cnt == cols_eff);
    iss_valid = accept && (sample_ok || flush_ok);

    iss_op.sample = sample_ok;
    iss_op.win_en = sample_ok && (row_pos != 16'd0) && (col_pos != '0);
    iss_op.emit   = flush_ok || iss_op.win_en ||
                    (sample_ok && (row_pos > 16'd1) && (col_pos == '0));
    iss_op.fl_top = flush_ok && (flush_cnt == '0);
    iss_op.fl_bot = flush_ok && f_last;
    iss_op.fl_mem = flush_ok && (flush_cnt != '0) && !f_last;
    iss_op.last   = flush_ok && f_last;

    iss_col   = col_pos;
    // column 0 writes back the last cell of the previous row
    iss_waddr = (col_pos == '0) ? cm1 : col_pos - IdxW'(1);
    iss_raddr = sample_ok ? col_pos : IdxW'(flush_cnt - CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_eff  <= CntW'(ColsRst);
      rows_eff  <= 16'd2048;
      nodata    <= 32'sh8000_0000;
      col_pos   <= '0;
      row_pos   <= '0;
      flush_cnt <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_COLUMNS: begin
            if (cols_wr < 12'd2) begin
              cols_eff <= CntW'(2);
            end else if (32'(cols_wr) > 32'(MAX_COLUMNS)) begin
              cols_eff <= CntW'(MAX_COLUMNS);
            end else begin
              cols_eff <= CntW'(cols_wr);
            end
          end
          CFG_ROWS: begin
            rows_eff <= (cfg_data[15:0] < 16'd2) ? 16'd2 : cfg_data[15:0];
          end
          CFG_NODATA: begin
            nodata <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      if (restart) begin
        col_pos   <= '0;
        row_pos   <= '0;
        flush_cnt <= '0;
      end else if (iss_valid && sample_ok) begin
        if (col_last) begin
          col_pos <= '0;
          row_pos <= row_pos + 16'd1;
        end else begin
          col_pos <= col_pos + IdxW'(1);
        end
      end else if (iss_valid && flush_ok) begin
        if (f_last) begin
          col_pos   <= '0;
          row_pos   <= '0;
          flush_cnt <= '0;
        end else begin
          flush_cnt <= flush_cnt + CntW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dwem_core.sv =====
// Window stage and output register: ranks the 2x2 window, updates the marks,
// writes back to the line memories and holds the result. Depends on dwem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dwem_core #(
  parameter int MAX_COLUMNS = 2048,
  localparam int IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               iss_valid,
  input  wire dwem_pkg::dwem_op_t iss_op,
  input  wire logic [IdxW-1:0]    iss_col,
  input  wire logic [IdxW-1:0]    iss_waddr,
  input  wire logic [IdxW-1:0]    iss_raddr,
  input  wire logic signed [31:0] elevation,
  input  wire logic signed [31:0] nodata,
  output logic                    in_ready,
  input  wire logic signed [31:0] elev_rdata,
  input  wire logic [1:0]         mark_rdata,
  output logic                    elev_we,
  output logic [IdxW-1:0]         elev_waddr,
  output logic [31:0]             elev_wdata,
  output logic                    mark_we,
  output logic [IdxW-1:0]         mark_waddr,
  output logic [1:0]              mark_wdata,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              mark,
  output logic                    frame_last
);

  import dwem_pkg::*;

  localparam logic [7:0] MarkHigh    = 8'd255;
  localparam logic [7:0] MarkNeutral = 8'd128;
  localparam logic [7:0] MarkLow     = 8'd0;

  // window stage
  logic               b_valid;
  dwem_op_t           b_op;
  logic [IdxW-1:0]    b_col;
  logic [IdxW-1:0]    b_waddr;
  logic signed [31:0] b_elev;
  logic               b_fwd_hit;
  dwem_code_t         b_fwd_code;
  logic               b_fire;

  // carries across the window: previous row at c-1, current row at c-1
  logic signed [31:0] ul_val;
  logic signed [31:0] ll_val;
  dwem_code_t         top_code;
  dwem_code_t         bot_code;

  logic signed [31:0] v [4];
  logic [3:0]         lt [4];
  logic [1:0]         ord [4];
  logic [1:0]         swp;
  dwem_code_t         cw [4];
  dwem_code_t         tr_code;
  dwem_code_t         res_code;
  logic               no_gap;

  function automatic logic [7:0] decode_mark(input dwem_code_t c);
    logic [7:0] m;
    unique case (c)
      CODE_HIGH: m = MarkHigh;
      CODE_LOW:  m = MarkLow;
      default:   m = MarkNeutral;
    endcase
    return m;
  endfunction

  assign b_fire   = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || b_fire;

  always_comb begin
    v[0] = ul_val;
    v[1] = elev_rdata;
    v[2] = ll_val;
    v[3] = b_elev;
    tr_code = b_fwd_hit ? b_fwd_code : dwem_code_t'(mark_rdata);
    no_gap  = (v[0] != nodata) && (v[1] != nodata) &&
              (v[2] != nodata) && (v[3] != nodata);

    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        lt[i][j] = (v[i] < v[j]);
      end
    end

    // exchange sort on indexes only; all compares are between original values
    swp = '0;
    for (int k = 0; k < 4; k++) begin
      ord[k] = 2'(k);
    end
    for (int m = 0; m < 3; m++) begin
      for (int n = m + 1; n < 4; n++) begin
        if (lt[ord[m]][ord[n]]) begin
          swp    = ord[m];
          ord[m] = ord[n];
          ord[n] = swp;
        end
      end
    end

    cw[0] = top_code;
    cw[1] = tr_code;
    cw[2] = bot_code;
    cw[3] = CODE_NEUTRAL;
    if (b_op.win_en && no_gap) begin
      cw[ord[0]] = CODE_HIGH;
      cw[ord[3]] = CODE_LOW;
    end

    if (b_op.fl_top) begin
      res_code = top_code;
    end else if (b_op.fl_mem) begin
      res_code = tr_code;
    end else if (b_op.fl_bot) begin
      res_code = bot_code;
    end else begin
      res_code = cw[0];
    end
  end

  assign elev_we    = b_fire && b_op.sample;
  assign elev_waddr = b_col;
  assign elev_wdata = b_elev;
  assign mark_we    = b_fire && b_op.sample;
  assign mark_waddr = b_waddr;
  assign mark_wdata = cw[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        b_valid <= iss_valid;
      end
      if (b_fire) begin
        out_valid <= b_op.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (iss_valid && in_ready) begin
      b_op    <= iss_op;
      b_col   <= iss_col;
      b_waddr <= iss_waddr;
      b_elev  <= elevation;
      // write-back in flight to the column being read: take it from here
      b_fwd_hit  <= mark_we && (mark_waddr == iss_raddr);
      b_fwd_code <= cw[2];
    end

    if (b_fire && b_op.sample) begin
      ul_val   <= elev_rdata;
      ll_val   <= b_elev;
      top_code <= cw[1];
      bot_code <= cw[3];
    end

    if (b_fire) begin
      mark       <= decode_mark(res_code);
      frame_last <= b_op.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dem_window_extrema_marker.sv =====
// Streaming 2x2 window extrema marker over a raster elevation stream.
// Each item passes through the window stage, then the output register, before
// out_valid rises for it. Throughput: one item per cycle unless out_ready holds
// the output, set by the single mark line read at issue and its write-back in
// the window stage (same-column overlap is forwarded).
// Reset clears the control state and config to its defaults; the line memories
// are not cleared and every entry is written before a value read from it is used.
`timescale 1ns / 1ps
`default_nettype none

module dem_window_extrema_marker #(
  parameter int MAX_COLUMNS = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dwem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           cmd,
  input  wire logic signed [31:0]             elevation,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          mark,
  output logic                                frame_last
);

  import dwem_pkg::*;

  localparam int IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic               accept;
  logic               iss_valid;
  dwem_op_t           iss_op;
  logic [IdxW-1:0]    iss_col;
  logic [IdxW-1:0]    iss_waddr;
  logic [IdxW-1:0]    iss_raddr;
  logic signed [31:0] nodata;

  logic               elev_we;
  logic [IdxW-1:0]    elev_waddr;
  logic [31:0]        elev_wdata;
  logic [31:0]        elev_rdata;
  logic               mark_we;
  logic [IdxW-1:0]    mark_waddr;
  logic [1:0]         mark_wdata;
  logic [1:0]         mark_rdata;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  dwem_seq #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .iss_valid (iss_valid),
    .iss_op    (iss_op),
    .iss_col   (iss_col),
    .iss_waddr (iss_waddr),
    .iss_raddr (iss_raddr),
    .nodata    (nodata)
  );

  // previous row of samples
  dwem_ram #(
    .WIDTH(32),
    .DEPTH(MAX_COLUMNS)
  ) u_elev_line (
    .clk   (clk),
    .we    (elev_we),
    .waddr (elev_waddr),
    .wdata (elev_wdata),
    .re    (iss_valid),
    .raddr (iss_col),
    .rdata (elev_rdata)
  );

  // previous row of mark codes
  dwem_ram #(
    .WIDTH(2),
    .DEPTH(MAX_COLUMNS)
  ) u_mark_line (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (iss_valid),
    .raddr (iss_raddr),
    .rdata (mark_rdata)
  );

  dwem_core #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .iss_valid  (iss_valid),
    .iss_op     (iss_op),
    .iss_col    (iss_col),
    .iss_waddr  (iss_waddr),
    .iss_raddr  (iss_raddr),
    .elevation  (elevation),
    .nodata     (nodata),
    .in_ready   (in_ready),
    .elev_rdata (elev_rdata),
    .mark_rdata (mark_rdata),
    .elev_we    (elev_we),
    .elev_waddr (elev_waddr),
    .elev_wdata (elev_wdata),
    .mark_we    (mark_we),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mark       (mark),
    .frame_last (frame_last)
  );

endmodule

`default_nettype wire
